// ----- sv/nds_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and register codes for the luma thumbnail block
package nds_pkg;

  localparam int unsigned SIZE_W   = 13;  // size registers and source counters
  localparam int unsigned SUM_W    = 26;  // running products of two sizes
  localparam int unsigned COORD_W  = 12;  // thumbnail coordinates on the result
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_SIDE = 4096;

  localparam logic [SIZE_W-1:0] RST_SRC_W = 13'd1920;
  localparam logic [SIZE_W-1:0] RST_SRC_H = 13'd1080;
  localparam logic [SIZE_W-1:0] RST_TH_W  = 13'd64;
  localparam logic [SIZE_W-1:0] RST_TH_H  = 13'd36;

  // rec.709 integer luma weights
  localparam logic [7:0] COEF_R = 8'd54;
  localparam logic [7:0] COEF_G = 8'd183;
  localparam logic [7:0] COEF_B = 8'd19;
  localparam int unsigned LUMA_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TH_W  = 2'd2,
    REG_TH_H  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] th_w;
    logic [SIZE_W-1:0] th_h;
    logic              sizes_ok;
  } size_cfg_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] thumb_x;
    logic [COORD_W-1:0] thumb_y;
    logic               last;
  } sample_t;

endpackage

// ----- sv/nds_if.sv -----
`timescale 1ns / 1ps
// handshake channel interfaces: source pixels, thumbnail results, register writes
interface nds_pix_if;
  logic                        valid;
  logic                        ready;
  logic [nds_pkg::COLOR_W-1:0] red;
  logic [nds_pkg::COLOR_W-1:0] green;
  logic [nds_pkg::COLOR_W-1:0] blue;
  logic                        frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface nds_res_if;
  logic                        valid;
  logic                        ready;
  logic [nds_pkg::LUMA_W-1:0]  luma;
  logic [nds_pkg::COORD_W-1:0] thumb_x;
  logic [nds_pkg::COORD_W-1:0] thumb_y;
  logic                        last_in_frame;

  modport source (output valid, luma, thumb_x, thumb_y, last_in_frame, input ready);
  modport sink (input valid, luma, thumb_x, thumb_y, last_in_frame, output ready);
endinterface

interface nds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nds_pkg::CFG_IDX_W-1:0] index;
  logic [nds_pkg::SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/nearest_downscale_luma_thumbnail_unit.sv -----
`timescale 1ns / 1ps
// top level of the nearest-neighbour luma thumbnail block
// Source pixels come in raster order on in_pix, one word per pixel; the block
// keeps its own source column and row and, for each pixel that is the nearest
// sample of a thumbnail pixel (column floor(tx*W/TW), row floor(ty*H/TH)),
// sends one word on out_res with its luma (54R+183G+19B)>>8, the thumbnail
// coordinates and a flag on the last thumbnail pixel of the frame. Other
// pixels give no word. frame_start on a pixel restarts the counters. Sizes are
// written on cfg_wr (0 source width, 1 source height, 2 thumb width, 3 thumb
// height); the user must write them only while the block is idle, which the
// block does not enforce. A zero size, a source side above MAX_SIDE or a
// thumbnail larger than the source disables all output. One pixel is taken
// every clock while the input is ready, which it is while the output register
// is empty or being drained, and gets each result in the cycle after its pixel.
module nearest_downscale_luma_thumbnail_unit #(
  parameter int unsigned MAX_SIDE = nds_pkg::DEF_MAX_SIDE
) (
  input  logic      clk,
  input  logic      rst_n,
  nds_pix_if.sink   in_pix,
  nds_res_if.source out_res,
  nds_cfg_if.sink   cfg_wr
);

  nds_pkg::size_cfg_t cfg;
  nds_pkg::sample_t   smp;

  logic                        in_acc;
  logic [nds_pkg::LUMA_W-1:0]  luma;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [nds_pkg::LUMA_W-1:0]  luma_r;
  logic [nds_pkg::COORD_W-1:0] thumb_x_r, thumb_y_r;
  logic                        last_r;

  // register writes are always taken
  assign cfg_wr.ready = 1'b1;

  nds_cfg_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .cfg      (cfg)
  );

  // accept whenever the result register is free or drains this cycle
  assign in_pix.ready = !out_valid_r || out_res.ready;
  assign in_acc       = in_pix.valid && in_pix.ready;

  nds_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .frame_start (in_pix.frame_start),
    .cfg         (cfg),
    .smp         (smp)
  );

  nds_luma u_luma (
    .red   (in_pix.red),
    .green (in_pix.green),
    .blue  (in_pix.blue),
    .luma  (luma)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = smp.hit;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only loads on a sampled pixel
  always_ff @(posedge clk) begin
    if (in_acc && smp.hit) begin
      luma_r    <= luma;
      thumb_x_r <= smp.thumb_x;
      thumb_y_r <= smp.thumb_y;
      last_r    <= smp.last;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.luma          = luma_r;
  assign out_res.thumb_x       = thumb_x_r;
  assign out_res.thumb_y       = thumb_y_r;
  assign out_res.last_in_frame = last_r;

endmodule

// ----- sv/nds_cfg_regs.sv -----
`timescale 1ns / 1ps
// size registers and the size validity check
module nds_cfg_regs #(
  parameter int unsigned MAX_SIDE = nds_pkg::DEF_MAX_SIDE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [nds_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [nds_pkg::SIZE_W-1:0]    wr_data,
  output nds_pkg::size_cfg_t            cfg
);

  logic [nds_pkg::SIZE_W-1:0] src_w_r, src_h_r, th_w_r, th_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nds_pkg::RST_SRC_W;
      src_h_r <= nds_pkg::RST_SRC_H;
      th_w_r  <= nds_pkg::RST_TH_W;
      th_h_r  <= nds_pkg::RST_TH_H;
    end else if (wr_en) begin
      unique case (nds_pkg::cfg_reg_t'(wr_index))
        nds_pkg::REG_SRC_W: src_w_r <= wr_data;
        nds_pkg::REG_SRC_H: src_h_r <= wr_data;
        nds_pkg::REG_TH_W:  th_w_r  <= wr_data;
        nds_pkg::REG_TH_H:  th_h_r  <= wr_data;
      endcase
    end
  end

  logic any_zero, too_big, upscale;

  assign any_zero = (src_w_r == '0) || (src_h_r == '0) || (th_w_r == '0) || (th_h_r == '0);
  assign too_big  = (32'(src_w_r) > MAX_SIDE) || (32'(src_h_r) > MAX_SIDE);
  assign upscale  = (th_w_r > src_w_r) || (th_h_r > src_h_r);

  assign cfg.src_w    = src_w_r;
  assign cfg.src_h    = src_h_r;
  assign cfg.th_w     = th_w_r;
  assign cfg.th_h     = th_h_r;
  assign cfg.sizes_ok = !(any_zero || too_big || upscale);

endmodule

// ----- sv/nds_track.sv -----
`timescale 1ns / 1ps
// source position counters and running sums that pick the sampled pixels
module nds_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               frame_start,
  input  nds_pkg::size_cfg_t cfg,
  output nds_pkg::sample_t   smp
);

  localparam int unsigned SW = nds_pkg::SIZE_W;
  localparam int unsigned MW = nds_pkg::SUM_W;

  logic [SW-1:0] src_col_r, src_row_r, nxt_tcol_r, nxt_trow_r;
  logic [MW-1:0] col_tgt_r, col_pos_r, row_tgt_r, row_pos_r;
  logic [SW-1:0] src_col_nxt, src_row_nxt, nxt_tcol_nxt, nxt_trow_nxt;
  logic [MW-1:0] col_tgt_nxt, col_pos_nxt, row_tgt_nxt, row_pos_nxt;

  // state as seen by this pixel, cleared on frame start
  logic [SW-1:0] sc, sr, tc, tr;
  logic [MW-1:0] ct, cp, rt, rp;
  logic          row_hit, col_hit, col_wrap, row_wrap;

  always_comb begin
    sc = frame_start ? '0 : src_col_r;
    sr = frame_start ? '0 : src_row_r;
    tc = frame_start ? '0 : nxt_tcol_r;
    tr = frame_start ? '0 : nxt_trow_r;
    ct = frame_start ? '0 : col_tgt_r;
    cp = frame_start ? '0 : col_pos_r;
    rt = frame_start ? '0 : row_tgt_r;
    rp = frame_start ? '0 : row_pos_r;

    row_hit = (tr < cfg.th_h) &&
              ({1'b0, rt} < ({1'b0, rp} + (MW+1)'(cfg.th_h)));
    col_hit = (tc < cfg.th_w) &&
              ({1'b0, ct} < ({1'b0, cp} + (MW+1)'(cfg.th_w)));
    col_wrap = sc >= (cfg.src_w - SW'(1));
    row_wrap = sr >= (cfg.src_h - SW'(1));

    src_col_nxt  = sc;
    src_row_nxt  = sr;
    nxt_tcol_nxt = tc;
    nxt_trow_nxt = tr;
    col_tgt_nxt  = ct;
    col_pos_nxt  = cp;
    row_tgt_nxt  = rt;
    row_pos_nxt  = rp;

    if (cfg.sizes_ok) begin
      if (col_wrap) begin
        src_col_nxt  = '0;
        nxt_tcol_nxt = '0;
        col_tgt_nxt  = '0;
        col_pos_nxt  = '0;
        if (row_wrap) begin
          src_row_nxt  = '0;
          nxt_trow_nxt = '0;
          row_tgt_nxt  = '0;
          row_pos_nxt  = '0;
        end else begin
          if (row_hit) begin
            nxt_trow_nxt = tr + SW'(1);
            row_tgt_nxt  = rt + MW'(cfg.src_h);
          end
          src_row_nxt = sr + SW'(1);
          row_pos_nxt = rp + MW'(cfg.th_h);
        end
      end else begin
        if (col_hit) begin
          nxt_tcol_nxt = tc + SW'(1);
          col_tgt_nxt  = ct + MW'(cfg.src_w);
        end
        src_col_nxt = sc + SW'(1);
        col_pos_nxt = cp + MW'(cfg.th_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      nxt_tcol_r <= '0;
      nxt_trow_r <= '0;
      col_tgt_r  <= '0;
      col_pos_r  <= '0;
      row_tgt_r  <= '0;
      row_pos_r  <= '0;
    end else if (step) begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      nxt_tcol_r <= nxt_tcol_nxt;
      nxt_trow_r <= nxt_trow_nxt;
      col_tgt_r  <= col_tgt_nxt;
      col_pos_r  <= col_pos_nxt;
      row_tgt_r  <= row_tgt_nxt;
      row_pos_r  <= row_pos_nxt;
    end
  end

  assign smp.hit     = cfg.sizes_ok && row_hit && col_hit;
  assign smp.thumb_x = tc[nds_pkg::COORD_W-1:0];
  assign smp.thumb_y = tr[nds_pkg::COORD_W-1:0];
  assign smp.last    = (tc == (cfg.th_w - SW'(1))) && (tr == (cfg.th_h - SW'(1)));

endmodule

// ----- sv/nds_luma.sv -----
`timescale 1ns / 1ps
// integer rec.709 luma from one rgb pixel
module nds_luma (
  input  logic [nds_pkg::COLOR_W-1:0] red,
  input  logic [nds_pkg::COLOR_W-1:0] green,
  input  logic [nds_pkg::COLOR_W-1:0] blue,
  output logic [nds_pkg::LUMA_W-1:0]  luma
);

  localparam int unsigned ACC_W = nds_pkg::COLOR_W + nds_pkg::LUMA_SHIFT;

  logic [ACC_W-1:0] acc;

  // weights sum to 256, so the top byte never exceeds 255
  assign acc = ACC_W'(red) * ACC_W'(nds_pkg::COEF_R)
             + ACC_W'(green) * ACC_W'(nds_pkg::COEF_G)
             + ACC_W'(blue) * ACC_W'(nds_pkg::COEF_B);

  assign luma = acc[ACC_W-1 -: nds_pkg::LUMA_W];

endmodule
